/* src/bfr_pkg.sv */
// Shared types and constants of the wraparound box filter row block.
// No dependencies; used by bfr_cfg and wraparound_box_filter_row.
package bfr_pkg;

  // register file geometry
  localparam int RADIUS_W   = 5;
  localparam int ROW_LEN_W  = 11;
  localparam int ADDR_W     = 3;
  localparam int REG_IDX_W  = 1;
  localparam int DATA_W     = 32;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_RADIUS     = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW_LENGTH = 1'd1;

  // register reset values
  localparam logic [RADIUS_W-1:0]  RADIUS_RST     = 5'd1;
  localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RST = 11'd600;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [RADIUS_W-1:0]  radius;
    logic [ROW_LEN_W-1:0] row_length;
    logic                 wr;
  } cfg_t;

endpackage

/* src/bfr_cfg.sv */
// APB-style configuration registers (radius, row length) of the box filter.
// Depends on bfr_pkg for register indexes, widths and the cfg_t struct.
module bfr_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bfr_pkg::ADDR_W-1:0]    paddr,
  input  logic [bfr_pkg::DATA_W-1:0]    pwdata,
  output logic [bfr_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output bfr_pkg::cfg_t                 cfg
);

  logic [bfr_pkg::RADIUS_W-1:0]  radius_r;
  logic [bfr_pkg::ROW_LEN_W-1:0] row_length_r;
  logic [bfr_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[bfr_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r     <= bfr_pkg::RADIUS_RST;
      row_length_r <= bfr_pkg::ROW_LENGTH_RST;
    end else if (wr_en) begin
      case (reg_idx)
        bfr_pkg::REG_RADIUS:     radius_r     <= pwdata[bfr_pkg::RADIUS_W-1:0];
        bfr_pkg::REG_ROW_LENGTH: row_length_r <= pwdata[bfr_pkg::ROW_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      bfr_pkg::REG_RADIUS:     prdata = bfr_pkg::DATA_W'(radius_r);
      bfr_pkg::REG_ROW_LENGTH: prdata = bfr_pkg::DATA_W'(row_length_r);
      default:                 prdata = '0;
    endcase
  end

  // any write transfer restarts the row
  assign cfg.radius     = radius_r;
  assign cfg.row_length = row_length_r;
  assign cfg.wr         = wr_en;

endmodule

/* src/bfr_line_mem.sv */
// Line memory of the box filter: one write port, two registered read ports.
// No dependencies.
module bfr_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, registered, hold while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* src/bfr_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with a shared enable.
// No dependencies; a tag travels alongside each division.
module bfr_div #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 6,
  parameter int QUO_W = 16,
  parameter int TAG_W = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [QUO_W-1:0] out_quo,
  output logic [TAG_W-1:0] out_tag
);

  logic             v_r   [NUM_W];
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] num_r [NUM_W];
  logic [NUM_W-1:0] quo_r [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];
  logic [TAG_W-1:0] tag_r [NUM_W];

  for (genvar j = 0; j < NUM_W; j++) begin : g_stage
    logic             v_i;
    logic [DEN_W-1:0] rem_i;
    logic [NUM_W-1:0] num_i;
    logic [NUM_W-1:0] quo_i;
    logic [DEN_W-1:0] den_i;
    logic [TAG_W-1:0] tag_i;
    logic [DEN_W:0]   sh;
    logic             ge;

    // stage input
    if (j == 0) begin : g_first
      assign v_i   = in_vld;
      assign rem_i = '0;
      assign num_i = in_num;
      assign quo_i = '0;
      assign den_i = in_den;
      assign tag_i = in_tag;
    end else begin : g_next
      assign v_i   = v_r[j-1];
      assign rem_i = rem_r[j-1];
      assign num_i = num_r[j-1];
      assign quo_i = quo_r[j-1];
      assign den_i = den_r[j-1];
      assign tag_i = tag_r[j-1];
    end

    // bring down the next dividend bit and try a subtract
    assign sh = {rem_i, num_i[NUM_W-1]};
    assign ge = sh >= {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? DEN_W'(sh - {1'b0, den_i}) : sh[DEN_W-1:0];
        num_r[j] <= {num_i[NUM_W-2:0], 1'b0};
        quo_r[j] <= {quo_i[NUM_W-2:0], ge};
        den_r[j] <= den_i;
        tag_r[j] <= tag_i;
      end
    end
  end

  assign out_vld = v_r[NUM_W-1];
  assign out_quo = quo_r[NUM_W-1][QUO_W-1:0];
  assign out_tag = tag_r[NUM_W-1];

endmodule

/* src/wraparound_box_filter_row.sv */
// Wraparound box filter over one row: running-sum datapath around a line memory.
// Depends on bfr_pkg, bfr_cfg, bfr_line_mem and bfr_div.
//
// Samples of a row are taken one per cycle while in_stall is low; each sample
// writes the line memory and reads back the sample leaving the window, and an
// adder stage keeps the running window sum. A result for position p leaves once
// sample p+r is in. After the last sample of a row the input stalls while the
// wrapped positions (L-r .. L-1, then 0 .. r-1) are formed, each one using
// both read ports of the line memory (entering sample and leaving sample).
// The average comes from a pipelined divider by 2r+1 with one stage per bit of
// the window sum (SAMPLE_BITS+$clog2(MAX_RADIUS+1)+1, 22 at the default
// parameters); the last divider stage is the output register.
// A stall on the result side freezes the whole pipeline.
// Any register write drops the partial row.
module wraparound_box_filter_row #(
  parameter int MAX_ROW     = 1024,
  parameter int MAX_RADIUS  = 31,
  parameter int SAMPLE_BITS = 16,
  localparam int IDX_W      = $clog2(MAX_ROW)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // sample channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [SAMPLE_BITS-1:0]          in_sample,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [SAMPLE_BITS-1:0]          out_average,
  output logic [IDX_W-1:0]                out_position,
  output logic                            out_row_done,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bfr_pkg::ADDR_W-1:0]      paddr,
  input  logic [bfr_pkg::DATA_W-1:0]      pwdata,
  output logic [bfr_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);

  localparam int LEN_W  = $clog2(MAX_ROW + 1);
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int DIV_W  = RAD_W + 1;
  localparam int SUM_W  = SAMPLE_BITS + DIV_W;
  localparam int CMP_W  = (LEN_W > bfr_pkg::ROW_LEN_W) ? LEN_W : bfr_pkg::ROW_LEN_W;
  localparam int TAG_W  = IDX_W + 1;
  localparam int BK_W   = RAD_W + 1;

  bfr_pkg::cfg_t cfg;

  // effective geometry
  logic [CMP_W-1:0] len_x;
  logic [CMP_W-1:0] half_x;
  logic [CMP_W-1:0] rad_a;
  logic [CMP_W-1:0] rad_b;
  logic [RAD_W-1:0] eff_rad;
  logic [DIV_W-1:0] span;

  // sequencer
  logic             adv;
  logic             in_acc;
  logic [IDX_W-1:0] idx_r;
  logic [CMP_W-1:0] idx_x;
  logic [CMP_W-1:0] idx_p1;
  logic             samp_last;
  logic             samp_sub_en;
  logic             samp_emit;
  logic [IDX_W-1:0] samp_sub_addr;
  logic [IDX_W-1:0] samp_pos;
  logic             burst_r;
  logic [BK_W-1:0]  bk_r;
  logic             bk_last;
  logic [IDX_W-1:0] badd_r;
  logic [IDX_W-1:0] bsub_r;
  logic [IDX_W-1:0] bpos_r;
  logic [IDX_W-1:0] bpos_nxt;

  // sum stage
  logic                   st1_v_r;
  logic                   st1_burst_r;
  logic                   st1_sub_en_r;
  logic                   st1_emit_r;
  logic                   st1_clear_r;
  logic [IDX_W-1:0]       st1_pos_r;
  logic [SAMPLE_BITS-1:0] st1_samp_r;
  logic [SAMPLE_BITS-1:0] rd_a;
  logic [SAMPLE_BITS-1:0] rd_b;
  logic [SAMPLE_BITS-1:0] add_v;
  logic [SAMPLE_BITS-1:0] sub_v;
  logic [SUM_W-1:0]       sum_r;
  logic [SUM_W-1:0]       sum_nxt;

  // divider side
  logic             div_vld;
  logic [TAG_W-1:0] div_tag;

  bfr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // saturate row length and radius
  always_comb begin
    if (CMP_W'(cfg.row_length) < CMP_W'(3)) begin
      len_x = CMP_W'(3);
    end else if (CMP_W'(cfg.row_length) > CMP_W'(MAX_ROW)) begin
      len_x = CMP_W'(MAX_ROW);
    end else begin
      len_x = CMP_W'(cfg.row_length);
    end
    half_x = (len_x - CMP_W'(1)) >> 1;
    if (CMP_W'(cfg.radius) < CMP_W'(1)) begin
      rad_a = CMP_W'(1);
    end else if (CMP_W'(cfg.radius) > CMP_W'(MAX_RADIUS)) begin
      rad_a = CMP_W'(MAX_RADIUS);
    end else begin
      rad_a = CMP_W'(cfg.radius);
    end
    rad_b = (rad_a > half_x) ? half_x : rad_a;
  end

  assign eff_rad = rad_b[RAD_W-1:0];
  assign span    = {eff_rad, 1'b1};

  // whole pipeline moves unless a result waits on a stalled receiver
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv || burst_r;
  assign in_acc   = in_valid && !in_stall;

  // per-sample addressing
  assign idx_x         = CMP_W'(idx_r);
  assign idx_p1        = idx_x + CMP_W'(1);
  assign samp_last     = idx_p1 == len_x;
  assign samp_sub_en   = idx_p1 > CMP_W'(span);
  assign samp_emit     = idx_p1 >= CMP_W'(span);
  assign samp_sub_addr = IDX_W'(idx_x - CMP_W'(span));
  assign samp_pos      = IDX_W'(idx_x - CMP_W'(eff_rad));

  // wrapped burst bookkeeping
  assign bk_last  = bk_r == ({eff_rad, 1'b0} - BK_W'(1));
  assign bpos_nxt = ((CMP_W'(bpos_r) + CMP_W'(1)) == len_x) ? '0 : bpos_r + IDX_W'(1);

  // row position and burst sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      burst_r <= 1'b0;
    end else if (cfg.wr) begin
      idx_r   <= '0;
      burst_r <= 1'b0;
    end else if (in_acc) begin
      if (samp_last) begin
        idx_r   <= '0;
        burst_r <= 1'b1;
      end else begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end else if (burst_r && adv && bk_last) begin
      burst_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      bk_r   <= '0;
      badd_r <= '0;
      bsub_r <= IDX_W'(len_x - CMP_W'(span));
      bpos_r <= IDX_W'(len_x - CMP_W'(eff_rad));
    end else if (burst_r && adv) begin
      bk_r   <= bk_r + BK_W'(1);
      badd_r <= badd_r + IDX_W'(1);
      bsub_r <= bsub_r + IDX_W'(1);
      bpos_r <= bpos_nxt;
    end
  end

  bfr_line_mem #(
    .DEPTH (MAX_ROW),
    .AW    (IDX_W),
    .DW    (SAMPLE_BITS)
  ) u_mem (
    .clk     (clk),
    .we      (in_acc),
    .waddr   (idx_r),
    .wdata   (in_sample),
    .re      (adv),
    .raddr_a (burst_r ? bsub_r : samp_sub_addr),
    .raddr_b (badd_r),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // sum stage control, aligned with the memory read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_v_r <= 1'b0;
    end else if (adv) begin
      st1_v_r <= in_acc || burst_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st1_burst_r  <= burst_r;
      st1_sub_en_r <= burst_r || samp_sub_en;
      st1_emit_r   <= burst_r || samp_emit;
      st1_clear_r  <= burst_r && bk_last;
      st1_pos_r    <= burst_r ? bpos_r : samp_pos;
      st1_samp_r   <= in_sample;
    end
  end

  // running window sum: add entering sample, drop leaving one
  assign add_v   = st1_burst_r ? rd_b : st1_samp_r;
  assign sub_v   = st1_sub_en_r ? rd_a : '0;
  assign sum_nxt = sum_r + SUM_W'(add_v) - SUM_W'(sub_v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (cfg.wr) begin
      sum_r <= '0;
    end else if (adv && st1_v_r) begin
      sum_r <= st1_clear_r ? '0 : sum_nxt;
    end
  end

  // divide by the window span; last stage is the output register
  bfr_div #(
    .NUM_W (SUM_W),
    .DEN_W (DIV_W),
    .QUO_W (SAMPLE_BITS),
    .TAG_W (TAG_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (st1_v_r && st1_emit_r),
    .in_num  (sum_nxt),
    .in_den  (span),
    .in_tag  ({st1_pos_r, st1_clear_r}),
    .out_vld (div_vld),
    .out_quo (out_average),
    .out_tag (div_tag)
  );

  assign out_valid    = div_vld;
  assign out_position = div_tag[TAG_W-1:1];
  assign out_row_done = div_tag[0];

endmodule
